// ----- rtl/opgp_hdr_pkg.sv -----
// Shared types and constants for the packet header encoder.
package opgp_hdr_pkg;

  localparam int unsigned HDR_BYTES = 6;
  localparam int unsigned IDX_W     = $clog2(HDR_BYTES);

  // One classified request: the header bytes in transmission order,
  // the index of the final byte and the error flag.
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [IDX_W-1:0]          last_idx;
    logic                      status;
  } desc_t;

endpackage

// ----- rtl/openpgp_packet_header_encoder_top.sv -----
// Top level of the packet header encoder: front end, descriptor queue, byte serializer.
//
// Input channel: a request (op_i, packet_type_i, body_length_i) transfers at a rising
// edge with push high and full low. op_i 0 selects the new header format, 1 the old
// one, 2 the old one with a forced two-byte length; anything else, or an old format
// with a packet type above 15, yields one error byte (out_byte 0, last 1, status 1).
// Result channel: one header byte per transfer, most significant length byte first;
// the byte is valid while empty is low and transfers at an edge with pop high.
// last_o marks the final byte of each header.
// The first byte of a request passes the descriptor queue, the current descriptor
// register and the output register. Throughput: one result byte per cycle while
// pop stays high; a request has 1 to 6 header bytes; the serializer sets the rate.
// Up to QUEUE_DEPTH classified requests wait ahead of the serializer, so requests
// keep transferring while earlier headers are still being sent.
// Reset empties the queue and the output register. When the receiver holds pop low
// the output byte holds, the serializer stops, and full rises once the queue fills.
module openpgp_packet_header_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [5:0]  packet_type_i,
  input  logic [31:0] body_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        status_o
);
  import opgp_hdr_pkg::*;

  desc_t fq_data, qb_data;
  logic  fq_push, fq_full, qb_pop, qb_empty;
  logic  first_q;

  opgp_hdr_front u_front (
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .packet_type_i (packet_type_i),
    .body_length_i (body_length_i),
    .q_full_i      (fq_full),
    .q_push_o      (fq_push),
    .q_data_o      (fq_data)
  );

  opgp_hdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_data),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .rdata_o (qb_data),
    .empty_o (qb_empty)
  );

  opgp_hdr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (qb_empty),
    .q_data_i   (qb_data),
    .q_pop_o    (qb_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .status_o   (status_o)
  );

  // track whether the byte on the result ports opens a header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (pop && !empty) begin
      first_q <= last_o;
    end
  end

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> last_o)
    else $error("error result not marked last");

  a_err_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (out_byte_o == 8'd0))
    else $error("error result carries a nonzero byte");

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> first_q)
    else $error("error result inside a header");

  a_tag_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && first_q && !status_o) |-> out_byte_o[7])
    else $error("header does not open with a tag byte");

endmodule

// ----- rtl/opgp_hdr_front.sv -----
// Front end: takes requests and builds the complete header descriptor.
module opgp_hdr_front (
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           op_i,
  input  logic [5:0]           packet_type_i,
  input  logic [31:0]          body_length_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output opgp_hdr_pkg::desc_t  q_data_o
);
  import opgp_hdr_pkg::*;

  localparam logic [1:0]  OP_NEW    = 2'd0;
  localparam logic [1:0]  OP_OLD    = 2'd1;
  localparam logic [1:0]  OP_OLD2   = 2'd2;
  localparam logic [31:0] NEW_ONE   = 32'd192;
  localparam logic [31:0] NEW_TWO   = 32'd8384;
  localparam logic [31:0] OLD_ONE   = 32'd256;
  localparam logic [31:0] OLD_TWO   = 32'd65536;
  localparam logic [7:0]  NEW_OFS   = 8'd192;
  localparam logic [7:0]  NEW_FIVE  = 8'hFF;

  function automatic desc_t classify(logic [1:0] op, logic [5:0] ptype, logic [31:0] len);
    desc_t       d;
    logic [12:0] ofs;
    logic [7:0]  tag;
    d          = '0;
    ofs        = len[12:0] - 13'd192;
    tag        = {2'b10, ptype[3:0], 2'b00};
    unique case (op)
      OP_NEW: begin
        d.hdr[0] = {2'b11, ptype};
        if (len == 32'd0) begin
          d.last_idx = IDX_W'(0);
        end else if (len < NEW_ONE) begin
          d.hdr[1]   = len[7:0];
          d.last_idx = IDX_W'(1);
        end else if (len < NEW_TWO) begin
          d.hdr[1]   = {3'b000, ofs[12:8]} + NEW_OFS;
          d.hdr[2]   = ofs[7:0];
          d.last_idx = IDX_W'(2);
        end else begin
          d.hdr[1]   = NEW_FIVE;
          d.hdr[2]   = len[31:24];
          d.hdr[3]   = len[23:16];
          d.hdr[4]   = len[15:8];
          d.hdr[5]   = len[7:0];
          d.last_idx = IDX_W'(5);
        end
      end
      OP_OLD, OP_OLD2: begin
        if (ptype[5:4] != 2'b00) begin
          d.status = 1'b1;
        end else if (op == OP_OLD2) begin
          d.hdr[0]   = tag | 8'd1;
          d.hdr[1]   = len[15:8];
          d.hdr[2]   = len[7:0];
          d.last_idx = IDX_W'(2);
        end else if (len == 32'd0) begin
          d.hdr[0]   = tag | 8'd3;
        end else if (len < OLD_ONE) begin
          d.hdr[0]   = tag;
          d.hdr[1]   = len[7:0];
          d.last_idx = IDX_W'(1);
        end else if (len < OLD_TWO) begin
          d.hdr[0]   = tag | 8'd1;
          d.hdr[1]   = len[15:8];
          d.hdr[2]   = len[7:0];
          d.last_idx = IDX_W'(2);
        end else begin
          d.hdr[0]   = tag | 8'd2;
          d.hdr[1]   = len[31:24];
          d.hdr[2]   = len[23:16];
          d.hdr[3]   = len[15:8];
          d.hdr[4]   = len[7:0];
          d.last_idx = IDX_W'(4);
        end
      end
      default: begin
        // unused format code: single error byte
        d.status = 1'b1;
      end
    endcase
    return d;
  endfunction

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;
  assign q_data_o = classify(op_i, packet_type_i, body_length_i);

endmodule

// ----- rtl/opgp_hdr_queue.sv -----
// Descriptor queue between the front end and the byte serializer.
module opgp_hdr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  opgp_hdr_pkg::desc_t  wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output opgp_hdr_pkg::desc_t  rdata_o,
  output logic                 empty_o
);
  import opgp_hdr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/opgp_hdr_back.sv -----
// Back end: walks a descriptor one byte per cycle into the free output register.
module opgp_hdr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  opgp_hdr_pkg::desc_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte_o,
  output logic                 last_o,
  output logic                 status_o
);
  import opgp_hdr_pkg::*;

  desc_t            cur_q;
  logic             cur_vld_q, cur_vld_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       byte_q;
  logic             last_q, status_q;
  logic             cur_last, out_free, emit, load;

  assign cur_last = (idx_q == cur_q.last_idx);
  assign out_free = !out_vld_q || pop;
  assign emit     = cur_vld_q && out_free;
  // take the next descriptor as soon as the current one sends its final byte
  assign load     = !q_empty_i && (!cur_vld_q || (emit && cur_last));
  assign q_pop_o  = load;

  always_comb begin
    cur_vld_d = cur_vld_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    if (load) begin
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end else if (emit) begin
      cur_vld_d = !cur_last;
      idx_d     = idx_q + IDX_W'(1);
    end
    if (out_free) begin
      out_vld_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      byte_q   <= cur_q.hdr[idx_q];
      last_q   <= cur_last;
      status_q <= cur_q.status;
    end
  end

  assign empty      = !out_vld_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;
  assign status_o   = status_q;

endmodule
